[src/pcb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared widths, register indexes, reset values and divider interface types
// for the palette cycle blender.
// ----------------------------------------------------------------------------
package pcb_pkg;

    localparam int GRADIENT_COUNT_DEF = 3;
    localparam int STEPS_DEF          = 12;
    localparam int REG_GROUPS         = 3;

    localparam int GRAD_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int COLOR_W    = 8;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int INDEX_W    = 8;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QM_W       = 4;
    localparam int CNT_W      = 6;
    localparam int CH_W       = 2;
    localparam int ACC_W      = COLOR_W + PERIOD_W;

    typedef logic [3*COLOR_W-1:0] rgb_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 3'd6;

    // Reset values
    localparam logic [INDEX_W-1:0]  RST_BASE_INDEX_0 = 8'd16;
    localparam logic [INDEX_W-1:0]  RST_BASE_INDEX_1 = 8'd32;
    localparam logic [INDEX_W-1:0]  RST_BASE_INDEX_2 = 8'd48;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_0     = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_1     = 16'd200;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_2     = 16'd300;
    localparam logic [MASK_W-1:0]   RST_REVERSE_MASK = 3'd3;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Channel codes
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    // Divider step counts
    localparam logic [CNT_W-1:0] DIV_TIME_STEPS = 6'd32;
    localparam logic [CNT_W-1:0] DIV_MIX_STEPS  = 6'd8;

    typedef struct packed {
        logic                go;
        logic [PERIOD_W-1:0] divisor;
        logic [PERIOD_W-1:0] rem_init;
        logic [TIME_W-1:0]   dvd_init;
        logic [CNT_W-1:0]    count;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [TIME_W-1:0]   quo;
        logic [PERIOD_W-1:0] rem;
        logic [QM_W-1:0]     qmod;
    } div_rsp_t;

endpackage
`default_nettype wire

[src/pcb_color_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_color_mem
// Base color store: one write port, two registered read ports. Per-entry
// valid bits make unwritten entries read as black after reset.
// ----------------------------------------------------------------------------
module pcb_color_mem #(
    parameter int DEPTH = pcb_pkg::GRADIENT_COUNT_DEF * pcb_pkg::STEPS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire pcb_pkg::rgb_t wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output pcb_pkg::rgb_t      rdata_a,
    output pcb_pkg::rgb_t      rdata_b
);
    import pcb_pkg::*;

    rgb_t             color_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    rgb_t             data_a_reg;
    rgb_t             data_b_reg;
    logic             valid_a_reg;
    logic             valid_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            color_mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_a_reg <= color_mem[raddr_a];
            data_b_reg <= color_mem[raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                valid_a_reg <= valid_reg[raddr_a];
                valid_b_reg <= valid_reg[raddr_b];
            end
        end
    end

    assign rdata_a = valid_a_reg ? data_a_reg : '0;
    assign rdata_b = valid_b_reg ? data_b_reg : '0;

endmodule
`default_nettype wire

[src/pcb_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_divider
// Restoring divider, one quotient bit per cycle. Runs a programmable number
// of steps from a preloaded partial remainder, and tracks quotient mod STEPS.
// ----------------------------------------------------------------------------
module pcb_divider #(
    parameter int STEPS = pcb_pkg::STEPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcb_pkg::div_req_t req,
    output pcb_pkg::div_rsp_t      rsp
);
    import pcb_pkg::*;

    localparam logic [QM_W:0] STEPS_Q = (QM_W + 1)'(STEPS);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;
    logic [PERIOD_W-1:0] div_reg, div_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0]   dvd_reg, dvd_next;
    logic [QM_W-1:0]     qmod_reg, qmod_next;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                q_bit;
    logic [QM_W:0]       qm_dbl;
    logic [QM_W:0]       qm_red;

    always_comb
    begin
        trial  = {rem_reg, dvd_reg[TIME_W-1]};
        diff   = trial - {1'b0, div_reg};
        q_bit  = (trial >= {1'b0, div_reg});
        // quotient enters MSB first, so its residue doubles each step
        qm_dbl = {qmod_reg, q_bit};
        qm_red = qm_dbl - STEPS_Q;

        count_next = count_reg;
        done_next  = 1'b0;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        qmod_next  = qmod_reg;

        if (req.go)
        begin
            count_next = req.count;
            div_next   = req.divisor;
            rem_next   = req.rem_init;
            dvd_next   = req.dvd_init;
            qmod_next  = '0;
        end
        else if (count_reg != '0)
        begin
            rem_next   = q_bit ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            dvd_next   = {dvd_reg[TIME_W-2:0], q_bit};
            qmod_next  = (qm_dbl >= STEPS_Q) ? qm_red[QM_W-1:0] : qm_dbl[QM_W-1:0];
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        qmod_reg <= qmod_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.qmod = qmod_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> (count_reg == '0))
        else $error("divider restarted while running");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_qmod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, qmod_reg} < STEPS_Q))
        else $error("quotient residue out of range");

endmodule
`default_nettype wire

[src/palette_cycle_blender.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// palette_cycle_blender
// A color load writes the base color store and gives no result. A tick blends
// every step of every gradient in turn, with a time division at the start of
// each gradient; the 8-step mix and 32-step time divisions share one divider,
// and one multiplier serves both blend passes.
// Throughput: one tick at a time; busy stays high until the last result.
// Reset: async active low; registers take their defaults, base colors read black.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module palette_cycle_blender #(
    parameter int GRADIENT_COUNT = pcb_pkg::GRADIENT_COUNT_DEF,
    parameter int STEPS          = pcb_pkg::STEPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            op,
    input  wire logic [pcb_pkg::GRAD_W-1:0]      gradient,
    input  wire logic [pcb_pkg::SLOT_W-1:0]      slot,
    input  wire logic [pcb_pkg::COLOR_W-1:0]     red_in,
    input  wire logic [pcb_pkg::COLOR_W-1:0]     green_in,
    input  wire logic [pcb_pkg::COLOR_W-1:0]     blue_in,
    input  wire logic [pcb_pkg::TIME_W-1:0]      time_now,
    output logic                                 result_strobe,
    output logic [pcb_pkg::INDEX_W-1:0]          palette_index,
    output logic [pcb_pkg::COLOR_W-1:0]          red_out,
    output logic [pcb_pkg::COLOR_W-1:0]          green_out,
    output logic [pcb_pkg::COLOR_W-1:0]          blue_out,
    output logic                                 last
);
    import pcb_pkg::*;

    localparam int DEPTH = GRADIENT_COUNT * STEPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(STEPS - 1);
    localparam logic [SLOT_W:0]   STEPS_X   = (SLOT_W + 1)'(STEPS);
    localparam logic [GRAD_W-1:0] LAST_GRAD = GRAD_W'(GRADIENT_COUNT - 1);
    localparam logic [AW-1:0]     STEPS_A   = AW'(STEPS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_T_GO   = 8'b0000_0010,
        S_T_WAIT = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_MUL_A  = 8'b0001_0000,
        S_MUL_B  = 8'b0010_0000,
        S_C_GO   = 8'b0100_0000,
        S_C_WAIT = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic [INDEX_W-1:0]  base_index_reg [REG_GROUPS];
    logic [PERIOD_W-1:0] period_reg [REG_GROUPS];
    logic [MASK_W-1:0]   reverse_mask_reg;

    // Control
    state_t            state_reg, state_next;
    logic [GRAD_W-1:0] g_reg, g_next;
    logic [AW-1:0]     gbase_reg, gbase_next;
    logic [SLOT_W-1:0] i_reg, i_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              strobe_reg, strobe_next;
    logic              last_reg, last_next;

    // Datapath
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [QM_W-1:0]     qm_reg, qm_next;
    logic [PERIOD_W-1:0] r_reg, r_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [COLOR_W-1:0]  mix_red_reg, mix_red_next;
    logic [COLOR_W-1:0]  mix_green_reg, mix_green_next;
    logic [INDEX_W-1:0]  palette_reg, palette_next;
    logic [COLOR_W-1:0]  red_out_reg, red_out_next;
    logic [COLOR_W-1:0]  green_out_reg, green_out_next;
    logic [COLOR_W-1:0]  blue_out_reg, blue_out_next;

    logic                accept;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    rgb_t                mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       raddr_a;
    logic [AW-1:0]       raddr_b;
    rgb_t                rd_a;
    rgb_t                rd_b;

    logic [PERIOD_W-1:0] p_sel;
    logic [PERIOD_W-1:0] p_eff;
    logic [SLOT_W:0]     c_sum;
    logic [SLOT_W:0]     c_red;
    logic [SLOT_W-1:0]   c_idx;
    logic [SLOT_W-1:0]   d_idx;
    logic [SLOT_W-1:0]   target;
    logic [COLOR_W-1:0]  a_chan;
    logic [COLOR_W-1:0]  b_chan;
    logic [COLOR_W-1:0]  mul_col;
    logic [PERIOD_W-1:0] mul_op;
    logic [ACC_W-1:0]    prod;
    logic [COLOR_W-1:0]  mix_val;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_index_reg[0] <= RST_BASE_INDEX_0;
            base_index_reg[1] <= RST_BASE_INDEX_1;
            base_index_reg[2] <= RST_BASE_INDEX_2;
            period_reg[0]     <= RST_PERIOD_0;
            period_reg[1]     <= RST_PERIOD_1;
            period_reg[2]     <= RST_PERIOD_2;
            reverse_mask_reg  <= RST_REVERSE_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_INDEX_0: base_index_reg[0] <= cfg_data[INDEX_W-1:0];
                REG_BASE_INDEX_1: base_index_reg[1] <= cfg_data[INDEX_W-1:0];
                REG_BASE_INDEX_2: base_index_reg[2] <= cfg_data[INDEX_W-1:0];
                REG_PERIOD_0:     period_reg[0]     <= cfg_data;
                REG_PERIOD_1:     period_reg[1]     <= cfg_data;
                REG_PERIOD_2:     period_reg[2]     <= cfg_data;
                REG_REVERSE_MASK: reverse_mask_reg  <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Base color store
    // ------------------------------------------------------------------
    assign mem_we    = accept && (op == OP_LOAD) && (int'(gradient) < GRADIENT_COUNT)
                       && (int'(slot) < STEPS);
    assign mem_waddr = AW'(int'(gradient) * STEPS + int'(slot));
    assign mem_wdata = {red_in, green_in, blue_in};
    assign mem_re    = (state_reg == S_READ);

    pcb_color_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // ------------------------------------------------------------------
    // Addressing and blend arithmetic
    // ------------------------------------------------------------------
    always_comb
    begin
        p_sel = period_reg[g_reg];
        p_eff = (p_sel == '0) ? PERIOD_W'(1) : p_sel;

        c_sum = {1'b0, i_reg} + {1'b0, qm_reg};
        c_red = c_sum - STEPS_X;
        c_idx = (c_sum >= STEPS_X) ? c_red[SLOT_W-1:0] : c_sum[SLOT_W-1:0];
        d_idx = (c_idx == LAST_STEP) ? '0 : c_idx + 1'b1;

        raddr_a = gbase_reg + AW'(c_idx);
        raddr_b = gbase_reg + AW'(d_idx);

        target = reverse_mask_reg[g_reg] ? (LAST_STEP - i_reg) : i_reg;

        case (ch_reg)
            CH_RED:
            begin
                a_chan = rd_a[3*COLOR_W-1:2*COLOR_W];
                b_chan = rd_b[3*COLOR_W-1:2*COLOR_W];
            end
            CH_GREEN:
            begin
                a_chan = rd_a[2*COLOR_W-1:COLOR_W];
                b_chan = rd_b[2*COLOR_W-1:COLOR_W];
            end
            default:
            begin
                a_chan = rd_a[COLOR_W-1:0];
                b_chan = rd_b[COLOR_W-1:0];
            end
        endcase

        // a*(p-r) on the first pass, b*r on the second
        mul_col = (state_reg == S_MUL_A) ? a_chan : b_chan;
        mul_op  = (state_reg == S_MUL_A) ? (p_eff - r_reg) : r_reg;
        prod    = ACC_W'(mul_col) * ACC_W'(mul_op);

        // numerator is at most 255*p, so the quotient fits in 8 bits
        mix_val = div_rsp.quo[COLOR_W-1:0];
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    always_comb
    begin
        div_req         = '0;
        div_req.divisor = p_eff;
        if (state_reg == S_T_GO)
        begin
            div_req.go       = 1'b1;
            div_req.rem_init = '0;
            div_req.dvd_init = time_reg;
            div_req.count    = DIV_TIME_STEPS;
        end
        else if (state_reg == S_C_GO)
        begin
            // upper bits of the numerator are already below p
            div_req.go       = 1'b1;
            div_req.rem_init = acc_reg[ACC_W-1:COLOR_W];
            div_req.dvd_init = {acc_reg[COLOR_W-1:0], (TIME_W - COLOR_W)'(0)};
            div_req.count    = DIV_MIX_STEPS;
        end
    end

    pcb_divider #(
        .STEPS (STEPS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        g_next         = g_reg;
        gbase_next     = gbase_reg;
        i_next         = i_reg;
        ch_next        = ch_reg;
        strobe_next    = 1'b0;
        last_next      = 1'b0;
        time_next      = time_reg;
        qm_next        = qm_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        mix_red_next   = mix_red_reg;
        mix_green_next = mix_green_reg;
        palette_next   = palette_reg;
        red_out_next   = red_out_reg;
        green_out_next = green_out_reg;
        blue_out_next  = blue_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_TICK))
                begin
                    time_next  = time_now;
                    g_next     = '0;
                    gbase_next = '0;
                    state_next = S_T_GO;
                end
            end
            S_T_GO:
            begin
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (div_rsp.done)
                begin
                    qm_next    = div_rsp.qmod;
                    r_next     = div_rsp.rem;
                    i_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ch_next    = CH_RED;
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                acc_next   = prod;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                acc_next   = acc_reg + prod;
                state_next = S_C_GO;
            end
            S_C_GO:
            begin
                state_next = S_C_WAIT;
            end
            S_C_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (ch_reg)
                        CH_RED:
                        begin
                            mix_red_next = mix_val;
                            ch_next      = CH_GREEN;
                            state_next   = S_MUL_A;
                        end
                        CH_GREEN:
                        begin
                            mix_green_next = mix_val;
                            ch_next        = CH_BLUE;
                            state_next     = S_MUL_A;
                        end
                        default:
                        begin
                            palette_next   = base_index_reg[g_reg] + INDEX_W'(target);
                            red_out_next   = mix_red_reg;
                            green_out_next = mix_green_reg;
                            blue_out_next  = mix_val;
                            strobe_next    = 1'b1;
                            last_next      = (i_reg == LAST_STEP) && (g_reg == LAST_GRAD);
                            if (i_reg == LAST_STEP)
                            begin
                                if (g_reg == LAST_GRAD)
                                begin
                                    state_next = S_IDLE;
                                end
                                else
                                begin
                                    g_next     = g_reg + 1'b1;
                                    gbase_next = gbase_reg + STEPS_A;
                                    state_next = S_T_GO;
                                end
                            end
                            else
                            begin
                                i_next     = i_reg + 1'b1;
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            g_reg      <= '0;
            gbase_reg  <= '0;
            i_reg      <= '0;
            ch_reg     <= CH_RED;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            g_reg      <= g_next;
            gbase_reg  <= gbase_next;
            i_reg      <= i_next;
            ch_reg     <= ch_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg      <= time_next;
        qm_reg        <= qm_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        mix_red_reg   <= mix_red_next;
        mix_green_reg <= mix_green_next;
        palette_reg   <= palette_next;
        red_out_reg   <= red_out_next;
        green_out_reg <= green_out_next;
        blue_out_reg  <= blue_out_next;
    end

    assign result_strobe = strobe_reg;
    assign last          = last_reg;
    assign palette_index = palette_reg;
    assign red_out       = red_out_reg;
    assign green_out     = green_out_reg;
    assign blue_out      = blue_out_reg;

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == S_C_WAIT && div_rsp.done))
        else $error("result strobe without a finished blend");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_strobe)
        else $error("last flag outside a result transfer");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> busy)
        else $error("tick ended before its final result");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy)) |-> $past(start && op == OP_TICK))
        else $error("busy raised without a tick");

endmodule
`default_nettype wire
